### hw/rtl/ifp_pkg.sv
// ----------------------------------------------------------------------------
// ifp_pkg
// Shared constants and types for the angle frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ifp_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'h55;
  localparam logic [7:0] HDR_SECOND = 8'h53;

  // Byte positions inside the 11-byte frame
  localparam logic [3:0] POS_BODY    = 4'd2;
  localparam logic [3:0] POS_PITCH_L = 4'd4;
  localparam logic [3:0] POS_PITCH_H = 4'd5;
  localparam logic [3:0] POS_YAW_L   = 4'd6;
  localparam logic [3:0] POS_YAW_H   = 4'd7;
  localparam logic [3:0] POS_CSUM    = 4'd10;

  // One decoded angle pair, raw codes (LSB = 180/32768 degree)
  typedef struct packed {
    logic signed [15:0] pitch_code;
    logic signed [15:0] yaw_code;
  } angle_t;

endpackage

`default_nettype wire

### hw/rtl/ifp_frame_fsm.sv
// ----------------------------------------------------------------------------
// ifp_frame_fsm
// Header hunt, byte counting, running checksum and angle byte capture.
// ----------------------------------------------------------------------------
`default_nettype none

module ifp_frame_fsm (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          take,
  input  wire logic [7:0]    rx_byte,
  output logic               hit,
  output ifp_pkg::angle_t    angle
);
  import ifp_pkg::*;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HDR2 = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [15:0] pitch_r, pitch_nxt;
  logic [15:0] yaw_r, yaw_nxt;
  logic        hit_nxt;

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    pitch_nxt = pitch_r;
    yaw_nxt   = yaw_r;
    hit_nxt   = 1'b0;
    case (phase_r)
      PH_HDR2: begin
        if (rx_byte == HDR_SECOND) begin
          sum_nxt   = sum_r + rx_byte;
          pos_nxt   = POS_BODY;
          phase_nxt = PH_BODY;
        end else begin
          // a repeated 0x55 here is not a new start
          phase_nxt = PH_HUNT;
          pos_nxt   = 4'd0;
        end
      end
      PH_BODY: begin
        if (pos_r >= POS_CSUM) begin
          hit_nxt   = (rx_byte == sum_r);
          phase_nxt = PH_HUNT;
          pos_nxt   = 4'd0;
        end else begin
          case (pos_r)
            POS_PITCH_L: pitch_nxt[7:0]  = rx_byte;
            POS_PITCH_H: pitch_nxt[15:8] = rx_byte;
            POS_YAW_L:   yaw_nxt[7:0]    = rx_byte;
            POS_YAW_H:   yaw_nxt[15:8]   = rx_byte;
            default: ;
          endcase
          sum_nxt = sum_r + rx_byte;
          pos_nxt = pos_r + 4'd1;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
        if (rx_byte == HDR_FIRST) begin
          sum_nxt   = rx_byte;
          pos_nxt   = 4'd1;
          phase_nxt = PH_HDR2;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      pos_r   <= 4'd0;
      sum_r   <= 8'd0;
      pitch_r <= 16'd0;
      yaw_r   <= 16'd0;
    end else if (take) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      sum_r   <= sum_nxt;
      pitch_r <= pitch_nxt;
      yaw_r   <= yaw_nxt;
    end
  end

  // Result is known in the checksum byte's cycle; angles are already held.
  assign hit              = take & hit_nxt;
  assign angle.pitch_code = pitch_r;
  assign angle.yaw_code   = yaw_r;

endmodule

`default_nettype wire

### hw/rtl/ifp_out_buf.sv
// ----------------------------------------------------------------------------
// ifp_out_buf
// Result register plus one skid entry; decouples output stall from input.
// ----------------------------------------------------------------------------
`default_nettype none

module ifp_out_buf (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire ifp_pkg::angle_t push_data,
  output logic               full,
  output logic               out_valid,
  input  wire logic          out_stall,
  output ifp_pkg::angle_t    out_data
);
  import ifp_pkg::*;

  logic   main_vld_r, skid_vld_r;
  angle_t main_r, skid_r;
  logic   pop;

  assign pop = main_vld_r & ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      // input is held off while the skid entry is occupied
      if (pop) begin
        main_r     <= skid_r;
        skid_vld_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_vld_r || pop) begin
        main_r     <= push_data;
        main_vld_r <= 1'b1;
      end else begin
        skid_r     <= push_data;
        skid_vld_r <= 1'b1;
      end
    end else if (pop) begin
      main_vld_r <= 1'b0;
    end
  end

  assign full      = skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_data  = main_r;

endmodule

`default_nettype wire

### hw/rtl/imu_angle_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// imu_angle_frame_parser_unit
// Angle frame parser: 0x55 0x53 header, eight body bytes, sum checksum.
// A good frame's angle pair is registered into the result register or skid entry.
// Throughput: one byte per cycle while in_stall is low; parser state updates in a single pass.
// in_stall rises only when the result register and its skid entry both hold.
// Reset (rst_n low, synchronous): parser hunts for 0x55, sum and angles zero.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_angle_frame_parser_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel: one serial byte per item
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_rx_byte,
  // result channel: one angle pair per good frame
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_pitch_code,
  output logic signed [15:0]      out_yaw_code
);
  import ifp_pkg::*;

  logic   take;
  logic   hit;
  logic   buf_full;
  angle_t angle;
  angle_t out_angle;

  // Accept a byte unless both output slots are taken. The stall is a
  // register output, so it never depends on in_valid.
  assign in_stall = buf_full;
  assign take     = in_valid & ~buf_full;

  // Header hunt, running checksum and pitch/yaw capture
  ifp_frame_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (in_rx_byte),
    .hit     (hit),
    .angle   (angle)
  );

  // Result register with skid entry; a bad checksum never pushes
  ifp_out_buf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (hit),
    .push_data (angle),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_angle)
  );

  assign out_pitch_code = out_angle.pitch_code;
  assign out_yaw_code   = out_angle.yaw_code;

endmodule

`default_nettype wire
